// File: hdl/nfpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfpa_pkg
// Types and constants shared by the next-fit page allocator and its channels.
// ----------------------------------------------------------------------------
package nfpa_pkg;

	localparam int PAGE_W     = 10;
	localparam int BOUND_W    = 11;
	localparam int MAX_PAGES  = 1024;
	localparam int WORD_BITS  = 64;
	localparam int WORD_SHIFT = 6;
	localparam int WNUM_W     = BOUND_W - WORD_SHIFT;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [PAGE_W-1:0]  USER_LO_RESET = 10'd1;
	localparam logic [BOUND_W-1:0] USER_HI_RESET = 11'd1024;

	typedef enum logic [1:0] {
		REQ_ALLOC = 2'd0,
		REQ_FREE  = 2'd1,
		REQ_SET   = 2'd2,
		REQ_NONE  = 2'd3
	} req_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_USER_LO = 1'b0,
		CFG_USER_HI = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_OP_WR,
		ST_SCAN,
		ST_RESP
	} nfpa_state_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] usable;
		logic [WORD_BITS-1:0] alloc;
	} mark_word_t;

endpackage

`default_nettype wire

// File: hdl/nfpa_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfpa channel interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface nfpa_req_if;
	logic                            valid;
	logic                            ready;
	nfpa_pkg::req_kind_t             req_type;
	logic [nfpa_pkg::PAGE_W-1:0]     page_index;
	logic                            usable;

	modport source (output valid, req_type, page_index, usable, input ready);
	modport sink   (input valid, req_type, page_index, usable, output ready);
endinterface

interface nfpa_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [nfpa_pkg::PAGE_W-1:0]     alloc_index;
	logic                            found;

	modport source (output valid, alloc_index, found, input ready);
	modport sink   (input valid, alloc_index, found, output ready);
endinterface

interface nfpa_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [nfpa_pkg::CFG_IDX_W-1:0]  index;
	logic [nfpa_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/next_fit_page_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// next_fit_page_allocator
// Next-fit page allocator over usable and allocated marks held in one memory.
// ----------------------------------------------------------------------------
// The marks sit in a single-port-per-direction memory of 64-page words (both
// marks per word); each request runs one item at a time. Free and set requests
// read their word in ST_SETUP and write it back in ST_OP_WR. An allocate scans
// one memory word per cycle from the next-fit pointer to the top of the window,
// then from user_lo back up to the pointer, the word that holds the pointer
// being read on both passes; an allocate over an empty window goes from
// ST_SETUP straight to ST_RESP with no scan. Rows of the memory carry valid
// bits cleared by reset, so no clearing pass follows reset. A new request is
// taken while the last response waits in the output register.
// ----------------------------------------------------------------------------
module next_fit_page_allocator #(
	parameter int PAGE_COUNT = 1024
) (
	input  wire          clk,
	input  wire          arst_n,
	nfpa_req_if.sink     req,
	nfpa_rsp_if.source   rsp,
	nfpa_cfg_if.sink     cfg
);

	localparam int PAGES = (PAGE_COUNT < nfpa_pkg::MAX_PAGES) ? PAGE_COUNT
	                                                          : nfpa_pkg::MAX_PAGES;
	localparam int DEPTH = (PAGES + nfpa_pkg::WORD_BITS - 1) / nfpa_pkg::WORD_BITS;
	localparam int WAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [nfpa_pkg::BOUND_W-1:0] PAGES_B = PAGES[nfpa_pkg::BOUND_W-1:0];

	typedef logic [nfpa_pkg::BOUND_W-1:0]   bound_t;
	typedef logic [nfpa_pkg::WNUM_W-1:0]    wnum_t;
	typedef logic [nfpa_pkg::WORD_BITS-1:0] wbits_t;
	typedef logic [nfpa_pkg::WORD_SHIFT-1:0] wbit_t;

	function automatic wbit_t first_set(input wbits_t v);
		wbit_t r;
		r = '0;
		for (int i = nfpa_pkg::WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = wbit_t'(i);
			end
		end
		return r;
	endfunction

	function automatic wnum_t word_of(input bound_t b);
		return b[nfpa_pkg::BOUND_W-1:nfpa_pkg::WORD_SHIFT];
	endfunction

	// marks memory
	nfpa_pkg::mark_word_t mem [DEPTH];
	logic [DEPTH-1:0]     row_vld_q;

	nfpa_pkg::nfpa_state_t state_q, state_d;

	logic [nfpa_pkg::PAGE_W-1:0] user_lo_q;
	bound_t                      user_hi_q;
	logic [nfpa_pkg::PAGE_W-1:0] ptr_q;

	nfpa_pkg::req_kind_t         req_q;
	logic [nfpa_pkg::PAGE_W-1:0] page_q;
	logic                        usable_q;

	bound_t start_q, hi_q;
	wnum_t  cur_q;
	logic   pass_q, stop_q;

	logic                 v_s1, pass_s1, last_s1, rd_vld_s1;
	wnum_t                w_s1;
	nfpa_pkg::mark_word_t rd_data_s1;

	logic [nfpa_pkg::PAGE_W-1:0] res_idx_q;
	logic                        res_found_q;
	logic                        out_valid_q;
	logic [nfpa_pkg::PAGE_W-1:0] out_idx_q;
	logic                        out_found_q;

	// combinational control
	logic                        rd_en, wr_en, issue, issue_last, scan_init;
	logic [WAW-1:0]              rd_addr, wr_addr;
	nfpa_pkg::mark_word_t        wr_data;
	logic                        res_ld, res_found_d, ptr_ld, out_ld;
	logic [nfpa_pkg::PAGE_W-1:0] res_idx_d, ptr_d;

	bound_t lo_b, ptr_b, page_b, hi_eff, start_ptr;
	logic   win_empty;
	wnum_t  hw, lw, pw, pgw;

	nfpa_pkg::mark_word_t eval_word, mod_word;
	bound_t               lb, ub;
	wnum_t                lbw, ubw;
	wbits_t               ge_mask, lt_mask, cand;
	logic                 hit;
	wbit_t                hit_bit;
	bound_t               hit_page;

	assign req.ready = (state_q == nfpa_pkg::ST_IDLE);
	assign cfg.ready = 1'b1;

	assign rsp.valid       = out_valid_q;
	assign rsp.alloc_index = out_idx_q;
	assign rsp.found       = out_found_q;

	assign lo_b      = {1'b0, user_lo_q};
	assign ptr_b     = {1'b0, ptr_q};
	assign page_b    = {1'b0, page_q};
	assign hi_eff    = (user_hi_q > PAGES_B) ? PAGES_B : user_hi_q;
	assign win_empty = (lo_b >= hi_eff);
	assign start_ptr = (ptr_b < lo_b || ptr_b >= hi_eff) ? lo_b : ptr_b;

	assign hw  = word_of(hi_q - bound_t'(1));
	assign lw  = word_of(lo_b);
	assign pw  = word_of(start_q);
	assign pgw = word_of(page_b);

	// scan word evaluation
	assign eval_word = rd_vld_s1 ? rd_data_s1 : '0;
	assign lb        = pass_s1 ? lo_b : start_q;
	assign ub        = pass_s1 ? start_q : hi_q;
	assign lbw       = word_of(lb);
	assign ubw       = word_of(ub);

	always_comb begin
		if (w_s1 > lbw) begin
			ge_mask = '1;
		end else if (w_s1 == lbw) begin
			ge_mask = '1 << lb[nfpa_pkg::WORD_SHIFT-1:0];
		end else begin
			ge_mask = '0;
		end
		if (w_s1 < ubw) begin
			lt_mask = '1;
		end else if (w_s1 == ubw) begin
			lt_mask = ~('1 << ub[nfpa_pkg::WORD_SHIFT-1:0]);
		end else begin
			lt_mask = '0;
		end
	end

	assign cand     = eval_word.usable & ~eval_word.alloc & ge_mask & lt_mask;
	assign hit      = v_s1 && (|cand);
	assign hit_bit  = first_set(cand);
	assign hit_page = {w_s1, hit_bit};

	// free and set update of the read word
	always_comb begin
		mod_word = eval_word;
		case (req_q)
			nfpa_pkg::REQ_FREE: begin
				mod_word.alloc[page_q[nfpa_pkg::WORD_SHIFT-1:0]] = 1'b0;
			end
			nfpa_pkg::REQ_SET: begin
				mod_word.usable[page_q[nfpa_pkg::WORD_SHIFT-1:0]] = usable_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d     = state_q;
		rd_en       = 1'b0;
		rd_addr     = cur_q[WAW-1:0];
		wr_en       = 1'b0;
		wr_addr     = w_s1[WAW-1:0];
		wr_data     = eval_word;
		issue       = 1'b0;
		issue_last  = 1'b0;
		scan_init   = 1'b0;
		res_ld      = 1'b0;
		res_idx_d   = '0;
		res_found_d = 1'b0;
		ptr_ld      = 1'b0;
		ptr_d       = user_lo_q;
		out_ld      = 1'b0;
		case (state_q)
			nfpa_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_d = nfpa_pkg::ST_SETUP;
				end
			end
			nfpa_pkg::ST_SETUP: begin
				if (req_q == nfpa_pkg::REQ_ALLOC) begin
					if (win_empty) begin
						ptr_ld  = 1'b1;
						res_ld  = 1'b1;
						state_d = nfpa_pkg::ST_RESP;
					end else begin
						scan_init = 1'b1;
						state_d   = nfpa_pkg::ST_SCAN;
					end
				end else if ((req_q == nfpa_pkg::REQ_FREE || req_q == nfpa_pkg::REQ_SET)
				             && page_b < PAGES_B) begin
					rd_en   = 1'b1;
					rd_addr = pgw[WAW-1:0];
					state_d = nfpa_pkg::ST_OP_WR;
				end else begin
					res_ld  = 1'b1;
					state_d = nfpa_pkg::ST_RESP;
				end
			end
			nfpa_pkg::ST_OP_WR: begin
				wr_en   = 1'b1;
				wr_addr = pgw[WAW-1:0];
				wr_data = mod_word;
				res_ld  = 1'b1;
				state_d = nfpa_pkg::ST_RESP;
			end
			nfpa_pkg::ST_SCAN: begin
				if (hit) begin
					wr_en                 = 1'b1;
					wr_data               = eval_word;
					wr_data.alloc[hit_bit] = 1'b1;
					ptr_ld                = 1'b1;
					ptr_d                 = hit_page[nfpa_pkg::PAGE_W-1:0];
					res_ld                = 1'b1;
					res_idx_d             = hit_page[nfpa_pkg::PAGE_W-1:0];
					res_found_d           = 1'b1;
					state_d               = nfpa_pkg::ST_RESP;
				end else if (v_s1 && last_s1) begin
					ptr_ld  = 1'b1;
					res_ld  = 1'b1;
					state_d = nfpa_pkg::ST_RESP;
				end else if (!stop_q) begin
					rd_en      = 1'b1;
					issue      = 1'b1;
					issue_last = pass_q ? (cur_q == pw) : (cur_q == hw && start_q == lo_b);
				end
			end
			nfpa_pkg::ST_RESP: begin
				if (!out_valid_q || rsp.ready) begin
					out_ld  = 1'b1;
					state_d = nfpa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = nfpa_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nfpa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// config registers, pointer, row valid bits and handshake state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_lo_q   <= nfpa_pkg::USER_LO_RESET;
			user_hi_q   <= nfpa_pkg::USER_HI_RESET;
			ptr_q       <= nfpa_pkg::USER_LO_RESET;
			row_vld_q   <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					nfpa_pkg::CFG_USER_LO: user_lo_q <= cfg.data[nfpa_pkg::PAGE_W-1:0];
					nfpa_pkg::CFG_USER_HI: user_hi_q <= cfg.data;
					default: begin
					end
				endcase
			end
			if (ptr_ld) begin
				ptr_q <= ptr_d;
			end
			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			v_s1 <= issue;
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			rd_vld_s1  <= row_vld_q[rd_addr];
		end
	end

	// request, scan and result registers
	always_ff @(posedge clk) begin
		if (req.valid && state_q == nfpa_pkg::ST_IDLE) begin
			req_q    <= req.req_type;
			page_q   <= req.page_index;
			usable_q <= req.usable;
		end
		if (state_q == nfpa_pkg::ST_SETUP) begin
			start_q <= start_ptr;
			hi_q    <= hi_eff;
		end
		if (scan_init) begin
			cur_q  <= word_of(start_ptr);
			pass_q <= 1'b0;
			stop_q <= 1'b0;
		end else if (issue) begin
			if (issue_last) begin
				stop_q <= 1'b1;
			end else if (!pass_q && cur_q == hw) begin
				pass_q <= 1'b1;
				cur_q  <= lw;
			end else begin
				cur_q <= cur_q + wnum_t'(1);
			end
		end
		if (issue) begin
			w_s1    <= cur_q;
			pass_s1 <= pass_q;
			last_s1 <= issue_last;
		end
		if (res_ld) begin
			res_idx_q   <= res_idx_d;
			res_found_q <= res_found_d;
		end
		if (out_ld) begin
			out_idx_q   <= res_idx_q;
			out_found_q <= res_found_q;
		end
	end

endmodule

`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for next_fit_page_allocator. A short stimulus table and
// then randomized allocate, free and set requests run over a series of user
// windows, each with one of four idle and stall patterns on the request and
// response channels. Fixed rows of the table are checked against their grant,
// others against a model of usable and allocated marks and next-fit pointer.
// ----------------------------------------------------------------------------
module tb;

	typedef struct packed {
		logic [nfpa_pkg::PAGE_W-1:0] alloc_index;
		logic                        found;
	} page_grant_t;

	typedef struct packed {
		nfpa_pkg::req_kind_t         kind;
		logic [nfpa_pkg::PAGE_W-1:0] page;
		logic                        mark;
		logic                        fixed;
		page_grant_t                 grant;
	} stim_row_t;

	typedef struct {
		int unsigned lo;
		int unsigned hi;
		int unsigned count;
	} window_phase_t;

	localparam int DIRECTED_ROWS = 25;
	localparam int FIXED_PHASES  = 8;
	localparam int PHASES        = 12;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 2 * (nfpa_pkg::MAX_PAGES / nfpa_pkg::WORD_BITS) + 8;

	localparam page_grant_t NO_GRANT = '{alloc_index: '0, found: 1'b0};

	logic clk = 1'b0;
	logic arst_n;

	nfpa_req_if req_ch ();
	nfpa_rsp_if rsp_ch ();
	nfpa_cfg_if cfg_ch ();

	next_fit_page_allocator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// model state
	bit [nfpa_pkg::MAX_PAGES-1:0] usable_map = '0;
	bit [nfpa_pkg::MAX_PAGES-1:0] taken_map  = '0;
	int unsigned        next_fit   = nfpa_pkg::USER_LO_RESET;
	int unsigned        win_lo     = nfpa_pkg::USER_LO_RESET;
	int unsigned        win_hi     = nfpa_pkg::USER_HI_RESET;

	page_grant_t pending_grants [$];
	logic        req_fixed;
	page_grant_t req_grant;
	int          fail_count  = 0;
	int unsigned cycle_count = 0;
	int          idle_pct    = 0;
	int          stall_pct   = 0;
	int unsigned cur_lo;
	int unsigned cur_hi;

	int IDLE_BY_MODE  [0:3] = '{0, 45, 0, 14};
	int STALL_BY_MODE [0:3] = '{0, 0, 45, 14};

	window_phase_t fixed_phases [0:FIXED_PHASES-1] = '{
		'{1, 1024, 60},
		'{1, 2, 25},
		'{1023, 1024, 25},
		'{100, 164, 60},
		'{60, 70, 60},
		'{1023, 2, 20},
		'{900, 1024, 60},
		'{3, 40, 60}
	};

	stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
		'{nfpa_pkg::REQ_ALLOC, 10'd0,    1'b0, 1'b1, '{10'd0, 1'b0}},
		'{nfpa_pkg::REQ_SET,   10'd1023, 1'b1, 1'b1, '{10'd0, 1'b0}},
		'{nfpa_pkg::REQ_SET,   10'd1,    1'b1, 1'b1, '{10'd0, 1'b0}},
		'{nfpa_pkg::REQ_SET,   10'd0,    1'b1, 1'b1, '{10'd0, 1'b0}},
		'{nfpa_pkg::REQ_ALLOC, 10'd0,    1'b0, 1'b1, '{10'd1, 1'b1}},
		'{nfpa_pkg::REQ_ALLOC, 10'd1023, 1'b1, 1'b0, '{10'd0, 1'b0}},
		'{nfpa_pkg::REQ_ALLOC, 10'd0,    1'b0, 1'b0, '{10'd0, 1'b0}},
		'{nfpa_pkg::REQ_FREE,  10'd1023, 1'b0, 1'b1, '{10'd0, 1'b0}},
		'{nfpa_pkg::REQ_ALLOC, 10'd512,  1'b1, 1'b0, '{10'd0, 1'b0}},
		'{nfpa_pkg::REQ_NONE,  10'd1023, 1'b1, 1'b1, '{10'd0, 1'b0}},
		'{nfpa_pkg::REQ_FREE,  10'd1,    1'b0, 1'b1, '{10'd0, 1'b0}},
		'{nfpa_pkg::REQ_SET,   10'd1023, 1'b0, 1'b1, '{10'd0, 1'b0}},
		'{nfpa_pkg::REQ_FREE,  10'd1023, 1'b1, 1'b1, '{10'd0, 1'b0}},
		'{nfpa_pkg::REQ_ALLOC, 10'd0,    1'b0, 1'b0, '{10'd0, 1'b0}},
		'{nfpa_pkg::REQ_SET,   10'd512,  1'b1, 1'b1, '{10'd0, 1'b0}},
		'{nfpa_pkg::REQ_SET,   10'd513,  1'b1, 1'b1, '{10'd0, 1'b0}},
		'{nfpa_pkg::REQ_ALLOC, 10'd0,    1'b0, 1'b0, '{10'd0, 1'b0}},
		'{nfpa_pkg::REQ_FREE,  10'd0,    1'b0, 1'b1, '{10'd0, 1'b0}},
		'{nfpa_pkg::REQ_NONE,  10'd0,    1'b0, 1'b1, '{10'd0, 1'b0}},
		'{nfpa_pkg::REQ_ALLOC, 10'd1023, 1'b0, 1'b0, '{10'd0, 1'b0}},
		'{nfpa_pkg::REQ_SET,   10'd1022, 1'b1, 1'b1, '{10'd0, 1'b0}},
		'{nfpa_pkg::REQ_ALLOC, 10'd0,    1'b0, 1'b0, '{10'd0, 1'b0}},
		'{nfpa_pkg::REQ_ALLOC, 10'd0,    1'b0, 1'b0, '{10'd0, 1'b0}},
		'{nfpa_pkg::REQ_SET,   10'd682,  1'b1, 1'b1, '{10'd0, 1'b0}},
		'{nfpa_pkg::REQ_SET,   10'd341,  1'b1, 1'b1, '{10'd0, 1'b0}}
	};

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic page_grant_t predict_grant(input nfpa_pkg::req_kind_t kind,
			input logic [nfpa_pkg::PAGE_W-1:0] page, input logic mark);
		page_grant_t grant;
		int unsigned top;
		int unsigned p;
		grant = NO_GRANT;
		case (kind)
			nfpa_pkg::REQ_ALLOC: begin
				top = (win_hi > nfpa_pkg::MAX_PAGES) ? nfpa_pkg::MAX_PAGES : win_hi;
				if (win_lo >= top) begin
					next_fit = win_lo;
				end else begin
					p = (next_fit < win_lo || next_fit >= top) ? win_lo : next_fit;
					for (int unsigned n = 0; n < top - win_lo && !grant.found; n++) begin
						if (usable_map[p] && !taken_map[p]) begin
							taken_map[p]      = 1'b1;
							next_fit          = p;
							grant.alloc_index = p[nfpa_pkg::PAGE_W-1:0];
							grant.found       = 1'b1;
						end else begin
							p++;
							if (p >= top)
								p = win_lo;
						end
					end
					if (!grant.found)
						next_fit = win_lo;
				end
			end
			nfpa_pkg::REQ_FREE: taken_map[page] = 1'b0;
			nfpa_pkg::REQ_SET:  usable_map[page] = mark;
			default: ;
		endcase
		return grant;
	endfunction

	always @(posedge clk) begin
		page_grant_t want;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (nfpa_pkg::cfg_reg_t'(cfg_ch.index))
					nfpa_pkg::CFG_USER_LO: win_lo = cfg_ch.data[nfpa_pkg::PAGE_W-1:0];
					nfpa_pkg::CFG_USER_HI: win_hi = cfg_ch.data;
					default: ;
				endcase
			end
			if (req_ch.valid && req_ch.ready) begin
				want = predict_grant(req_ch.req_type, req_ch.page_index, req_ch.usable);
				if (req_fixed)
					want = req_grant;
				pending_grants.push_back(want);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_grants.size() == 0) begin
					$error("unexpected response: alloc_index %0d found %0d",
						rsp_ch.alloc_index, rsp_ch.found);
					fail_count++;
				end else begin
					want = pending_grants.pop_front();
					if (rsp_ch.alloc_index !== want.alloc_index) begin
						$error("alloc_index: expected %0d, got %0d",
							want.alloc_index, rsp_ch.alloc_index);
						fail_count++;
					end
					if (rsp_ch.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, rsp_ch.found);
						fail_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_request(input nfpa_pkg::req_kind_t kind,
			input logic [nfpa_pkg::PAGE_W-1:0] page,
			input logic mark, input logic fixed, input page_grant_t grant);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= kind;
		req_ch.page_index <= page;
		req_ch.usable     <= mark;
		req_fixed         <= fixed;
		req_grant         <= grant;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_random_request();
		nfpa_pkg::req_kind_t         kind;
		logic [nfpa_pkg::PAGE_W-1:0] page;
		int unsigned                 roll;
		int unsigned                 top;
		int unsigned                 pick;
		roll = $urandom_range(99);
		if (roll < 40)
			kind = nfpa_pkg::REQ_ALLOC;
		else if (roll < 62)
			kind = nfpa_pkg::REQ_FREE;
		else if (roll < 95)
			kind = nfpa_pkg::REQ_SET;
		else
			kind = nfpa_pkg::REQ_NONE;
		top = (cur_hi > nfpa_pkg::MAX_PAGES) ? nfpa_pkg::MAX_PAGES : cur_hi;
		if (cur_lo < top && $urandom_range(9) < 8)
			pick = cur_lo + $urandom_range(top - cur_lo - 1);
		else
			pick = $urandom_range(nfpa_pkg::MAX_PAGES - 1);
		page = pick[nfpa_pkg::PAGE_W-1:0];
		send_request(kind, page, $urandom_range(4) != 0, 1'b0, NO_GRANT);
	endtask

	task automatic drain_grants();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input nfpa_pkg::cfg_reg_t which,
			input logic [nfpa_pkg::CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= which;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		window_phase_t ph;
		req_ch.valid      = 1'b0;
		req_ch.req_type   = nfpa_pkg::REQ_ALLOC;
		req_ch.page_index = '0;
		req_ch.usable     = 1'b0;
		req_fixed         = 1'b0;
		req_grant         = NO_GRANT;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = nfpa_pkg::CFG_USER_LO;
		cfg_ch.data       = '0;
		arst_n            = 1'b0;
		cur_lo            = nfpa_pkg::USER_LO_RESET;
		cur_hi            = nfpa_pkg::USER_HI_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].kind, directed_rows[i].page, directed_rows[i].mark,
				directed_rows[i].fixed, directed_rows[i].grant);
		drain_grants();

		for (int i = 0; i < PHASES; i++) begin
			if (i < FIXED_PHASES) begin
				ph = fixed_phases[i];
			end else begin
				ph.lo    = $urandom_range(nfpa_pkg::MAX_PAGES - 1, 1);
				ph.hi    = ph.lo + $urandom_range(80, 1);
				ph.hi    = (ph.hi > nfpa_pkg::MAX_PAGES) ? nfpa_pkg::MAX_PAGES : ph.hi;
				ph.count = 40;
			end
			write_register(nfpa_pkg::CFG_USER_LO, ph.lo[nfpa_pkg::CFG_DATA_W-1:0]);
			write_register(nfpa_pkg::CFG_USER_HI, ph.hi[nfpa_pkg::CFG_DATA_W-1:0]);
			cur_lo    = ph.lo;
			cur_hi    = ph.hi;
			idle_pct  = IDLE_BY_MODE[i % 4];
			stall_pct = STALL_BY_MODE[i % 4];
			for (int k = 0; k < ph.count; k++) begin
				// hold off mid-phase until every response is back
				if (k == ph.count / 2)
					drain_grants();
				send_random_request();
			end
			drain_grants();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
